// ===== src/lru_key_value_cache_unit_macros.svh =====
// ----------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Shared concurrent assertion forms for the cache unit. Each macro expands to
// one labeled assertion that is disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define LRUKV_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold at the next edge.
`define LRUKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lrukv_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Field widths, operation codes, reset values and the request and response
// transfer types of the cache unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrukv_pkg;

    localparam int KEY_W = 16;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam int DEFAULT_MAX_ENTRIES = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried in the request.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Value returned by a get that misses and by every put.
    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

    typedef struct packed {
        logic                    operation;
        logic [KEY_W-1:0]        lookup_key;
        logic signed [VAL_W-1:0] store_value;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic [KEY_W-1:0]        evicted_key;
    } rsp_t;

endpackage

`default_nettype wire

// ===== src/lru_key_value_cache_unit.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache unit
// Fully associative key/value store with least-recently-used replacement,
// built as a register-based CAM with a per-entry age counter.
// ----------------------------------------------------------------------------
//
//  Channel    Handshake                 Payload          Direction
//  ---------  ------------------------  ---------------  ---------
//  request    req_valid / req_stall     req (req_t)      in
//  response   rsp_valid / rsp_stall     rsp (rsp_t)      out
//  config     cfg_write_en              cfg_write_data   in
//
//  One request transfer is taken per clock while req_stall is low. The parallel
//  key compare and age update over all MAX_ENTRIES rows sit between the request
//  and response registers, and the result is registered before it is presented.
//  Reset clears the valid marks, the ages, the fill count and sets the
//  capacity to sixteen; keys and values are not cleared.
//  A stalled response holds the result register; an item behind it holds the
//  request register and the request side sees req_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_key_value_cache_unit_macros.svh"

module lru_key_value_cache_unit #(
    parameter int MAX_ENTRIES = lrukv_pkg::DEFAULT_MAX_ENTRIES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire lrukv_pkg::req_t               req,

    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output lrukv_pkg::rsp_t                    rsp,

    input  wire logic                          cfg_write_en,
    input  wire logic [lrukv_pkg::CAP_W-1:0]   cfg_write_data
);

    // Ages run from zero (most recent) to the fill count minus one.
    localparam int AGE_W = $clog2(MAX_ENTRIES);
    // The fill count must be able to hold MAX_ENTRIES itself.
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    // Common width for comparing the fill count against the capacity.
    localparam int LIM_W = (CNT_W > lrukv_pkg::CAP_W) ? CNT_W : lrukv_pkg::CAP_W;

    typedef logic [AGE_W-1:0] age_t;
    typedef logic [MAX_ENTRIES-1:0] row_mask_t;

    // Pipeline registers.
    logic                req_valid_reg;
    lrukv_pkg::req_t     req_reg;
    logic                rsp_valid_reg;
    lrukv_pkg::rsp_t     rsp_reg;
    lrukv_pkg::rsp_t     rsp_next;

    // Entry storage. Keys and values are only ever read from valid rows.
    logic [lrukv_pkg::KEY_W-1:0]        key_reg   [MAX_ENTRIES];
    logic signed [lrukv_pkg::VAL_W-1:0] value_reg [MAX_ENTRIES];
    row_mask_t                          valid_reg;
    row_mask_t                          valid_next;
    age_t                               age_reg   [MAX_ENTRIES];
    age_t                               age_next  [MAX_ENTRIES];
    logic [CNT_W-1:0]                   used_reg;
    logic [CNT_W-1:0]                   used_next;
    logic [lrukv_pkg::CAP_W-1:0]        cap_reg;
    logic [lrukv_pkg::CAP_W-1:0]        cap_next;

    // Lookup and replacement decode.
    logic                               rsp_free;
    logic                               advance;
    row_mask_t                          match;
    row_mask_t                          free_oh;
    row_mask_t                          victim;
    row_mask_t                          sel;
    logic                               is_put;
    logic                               is_hit;
    logic                               do_insert;
    logic                               do_evict;
    logic                               touch;
    logic signed [lrukv_pkg::VAL_W-1:0] hit_value;
    age_t                               hit_age;
    age_t                               oldest_age;
    age_t                               age_limit;
    logic [CNT_W-1:0]                   used_dec;
    logic [LIM_W-1:0]                   cap_ext;
    logic [LIM_W-1:0]                   live_cap;
    logic                               store_full;
    logic [lrukv_pkg::KEY_W-1:0]        victim_key;

    // The result register is free when it is empty or being taken this cycle.
    // The request register moves its item forward whenever that is so.
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign advance   = req_valid_reg && rsp_free;
    assign req_stall = req_valid_reg && !rsp_free;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Effective capacity: zero acts as one, and anything above the number of
    // rows is limited to the number of rows.
    always_comb
    begin
        cap_ext = LIM_W'(cap_reg);
        if (cap_ext == '0)
        begin
            live_cap = LIM_W'(1);
        end
        else if (cap_ext > LIM_W'(MAX_ENTRIES))
        begin
            live_cap = LIM_W'(MAX_ENTRIES);
        end
        else
        begin
            live_cap = cap_ext;
        end
        store_full = LIM_W'(used_reg) >= live_cap;
    end

    // Valid rows always carry the distinct ages 0 .. used-1, so the least
    // recent row is simply the one whose age equals used-1. The lowest free
    // row comes from the classic lowest-zero-bit trick on the valid mask.
    assign used_dec   = used_reg - CNT_W'(1);
    assign oldest_age = used_dec[AGE_W-1:0];
    assign free_oh    = ~valid_reg & (valid_reg + row_mask_t'(1));
    assign is_put     = req_reg.operation == lrukv_pkg::OP_PUT;

    always_comb
    begin
        hit_value  = '0;
        hit_age    = '0;
        victim_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match[i]  = valid_reg[i] && (key_reg[i] == req_reg.lookup_key);
            victim[i] = valid_reg[i] && (age_reg[i] == oldest_age);
            // Keys of valid rows are distinct, so at most one row matches and
            // an AND-OR mux picks its fields.
            hit_value  = hit_value  | (match[i]  ? value_reg[i] : '0);
            hit_age    = hit_age    | (match[i]  ? age_reg[i]   : '0);
            victim_key = victim_key | (victim[i] ? key_reg[i]   : '0);
        end
    end

    assign is_hit    = |match;
    assign do_insert = is_put && !is_hit && !store_full;
    assign do_evict  = is_put && !is_hit && store_full;
    assign touch     = is_hit || is_put;
    assign age_limit = is_hit ? hit_age : oldest_age;

    always_comb
    begin
        if (is_hit)
        begin
            sel = match;
        end
        else if (do_insert)
        begin
            sel = free_oh;
        end
        else if (do_evict)
        begin
            sel = victim;
        end
        else
        begin
            sel = '0;
        end
    end

    // Recency update: the selected row becomes age zero, and every valid row
    // younger than the selected row's old age steps back by one. A fresh
    // insert into a free row ages every valid row.
    always_comb
    begin
        valid_next = valid_reg;
        used_next  = used_reg;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            age_next[i] = age_reg[i];
            if (advance && touch)
            begin
                if (sel[i])
                begin
                    age_next[i] = '0;
                end
                else if (valid_reg[i] && (do_insert || (age_reg[i] < age_limit)))
                begin
                    age_next[i] = age_reg[i] + age_t'(1);
                end
            end
        end
        if (advance && do_insert)
        begin
            valid_next = valid_reg | free_oh;
            used_next  = used_reg + CNT_W'(1);
        end
    end

    // The capacity changes only while the store is empty.
    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_write_en && (used_reg == '0))
        begin
            cap_next = cfg_write_data;
        end
    end

    always_comb
    begin
        rsp_next.hit         = is_hit;
        rsp_next.read_value  = (is_hit && !is_put) ? hit_value : lrukv_pkg::MISS_VALUE;
        rsp_next.evicted     = do_evict;
        rsp_next.evicted_key = do_evict ? victim_key : '0;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            valid_reg     <= '0;
            used_reg      <= '0;
            cap_reg       <= lrukv_pkg::CAP_RESET;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            if (!req_stall)
            begin
                req_valid_reg <= req_valid;
            end
            if (rsp_free)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
            valid_reg <= valid_next;
            used_reg  <= used_next;
            cap_reg   <= cap_next;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    // Payload registers and entry contents.
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (advance && sel[i] && is_put)
            begin
                value_reg[i] <= req_reg.store_value;
            end
            if (advance && sel[i] && !is_hit)
            begin
                key_reg[i] <= req_reg.lookup_key;
            end
        end
    end

    // The fill count tracks the number of valid rows.
    `LRUKV_ASSERT_ALWAYS(a_used_count, clk, rst_n,
        CNT_W'($countones(valid_reg)) == used_reg, "fill count differs from valid rows")

    // Valid keys are unique, so a lookup never matches two rows.
    `LRUKV_ASSERT_ALWAYS(a_single_match, clk, rst_n,
        $onehot0(match), "lookup matched more than one row")

    // The store never grows past its effective capacity.
    `LRUKV_ASSERT_ALWAYS(a_within_cap, clk, rst_n,
        LIM_W'(used_reg) <= live_cap, "fill count above capacity")

    // A put that misses on a full store reports an eviction in its response.
    `LRUKV_ASSERT_NEXT(a_evict_reported, clk, rst_n, advance && do_evict,
        rsp_valid_reg && rsp_reg.evicted, "eviction not reported")

endmodule

`default_nettype wire
